FILE: src/color_mask_centroid_defines.svh
// ----------------------------------------------------------------------------
// Color mask centroid assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_MASK_CENTROID_DEFINES_SVH
`define COLOR_MASK_CENTROID_DEFINES_SVH

// Consequence must hold in the same cycle as the condition.
`define CMC_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define CMC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: src/cmc_pkg.sv
// ----------------------------------------------------------------------------
// Color mask centroid package
// Field widths, register codes and reset values, queue entry type and the
// small arithmetic helpers shared by the pixel front end and the back end.
// ----------------------------------------------------------------------------
package cmc_pkg;

  // Field widths.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned CENT_W  = 10;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_REF_CH0   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_CH1   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_CH2   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 3'd4;

  // Register reset values.
  localparam logic [CH_W-1:0]  REF_CH0_RESET   = 8'd175;
  localparam logic [CH_W-1:0]  REF_CH1_RESET   = 8'd220;
  localparam logic [CH_W-1:0]  REF_CH2_RESET   = 8'd160;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 10'd20;
  localparam logic             MODE_RESET      = 1'b1;

  // Distance modes.
  localparam logic MODE_SAD = 1'b0;
  localparam logic MODE_HUE = 1'b1;

  // Hue wraps at 180, so a difference above 90 is folded back.
  localparam logic [CH_W-1:0] HUE_HALF = 8'd90;
  localparam logic [CH_W-1:0] HUE_FULL = 8'd180;

  // Divide by three of an 8-bit value: multiply by 171, shift right by 9.
  localparam int unsigned     THIRD_SHIFT = 9;
  localparam logic [CH_W-1:0] THIRD_RECIP = 8'd171;

  // Hard limit on the per-frame match count.
  localparam int unsigned COUNT_HARD_CAP = 1048576;

  // Parameter defaults.
  localparam int unsigned MAX_WIDTH_DEFAULT   = 1024;
  localparam int unsigned MAX_HEIGHT_DEFAULT  = 1024;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // One classified pixel on its way to the back end. The sums and count are
  // the frame totals including this pixel; they matter only at frame end.
  typedef struct packed {
    logic               mask_bit;
    logic               end_of_frame;
    logic [SUM_W-1:0]   column_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [COUNT_W-1:0] pixel_count;
  } q_entry_t;

  // Absolute difference of two channel values.
  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: src/cmc_interfaces.sv
// ----------------------------------------------------------------------------
// Color mask centroid channel interfaces
// Valid/ready channels for incoming pixels and outgoing results.
// ----------------------------------------------------------------------------

// Pixel channel: one request per pixel.
interface cmc_pixel_if;
  import cmc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_0;
  logic [CH_W-1:0]    channel_1;
  logic [CH_W-1:0]    channel_2;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic               end_of_frame;

  modport source (
    output valid, channel_0, channel_1, channel_2, pixel_x, pixel_y, end_of_frame,
    input  ready
  );

  modport sink (
    input  valid, channel_0, channel_1, channel_2, pixel_x, pixel_y, end_of_frame,
    output ready
  );
endinterface

// Result channel: one request per pixel, centroid fields set at frame end.
interface cmc_result_if;
  import cmc_pkg::*;

  logic               valid;
  logic               ready;
  logic               mask_bit;
  logic               frame_done;
  logic [CENT_W-1:0]  centroid_x;
  logic [CENT_W-1:0]  centroid_y;
  logic [COUNT_W-1:0] match_count;

  modport source (
    output valid, mask_bit, frame_done, centroid_x, centroid_y, match_count,
    input  ready
  );

  modport sink (
    input  valid, mask_bit, frame_done, centroid_x, centroid_y, match_count,
    output ready
  );
endinterface

FILE: src/cmc_front.sv
// ----------------------------------------------------------------------------
// Color mask centroid front end
// Holds the configuration registers, classifies each pixel against the
// reference color, keeps the running frame sums and pushes one entry per
// pixel into the queue.
// ----------------------------------------------------------------------------
`include "color_mask_centroid_defines.svh"

module cmc_front #(
  parameter int unsigned MAX_WIDTH  = cmc_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT = cmc_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  cmc_pixel_if.sink                         pix,
  input  logic                              cfg_wen,
  input  logic [cmc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              push_valid,
  output cmc_pkg::q_entry_t                 push_data,
  input  logic                              push_ready
);
  import cmc_pkg::*;

  localparam int unsigned FrameArea = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned CountCap  =
    (FrameArea < COUNT_HARD_CAP) ? FrameArea : COUNT_HARD_CAP;

  logic [CH_W-1:0]    ref_channel_0;
  logic [CH_W-1:0]    ref_channel_1;
  logic [CH_W-1:0]    ref_channel_2;
  logic [THR_W-1:0]   match_threshold;
  logic               distance_mode;

  logic [SUM_W-1:0]   column_sum;
  logic [SUM_W-1:0]   row_sum;
  logic [COUNT_W-1:0] pixel_count;
  logic [SUM_W-1:0]   column_sum_next;
  logic [SUM_W-1:0]   row_sum_next;
  logic [COUNT_W-1:0] pixel_count_next;

  logic [CH_W-1:0]    diff_0;
  logic [CH_W-1:0]    diff_1;
  logic [CH_W-1:0]    diff_2;
  logic [CH_W-1:0]    hue_term;
  logic [2*CH_W-1:0]  sat_product;
  logic [CH_W-1:0]    sat_third;
  logic [DIST_W-1:0]  distance;
  logic               match;
  logic               add_pixel;
  logic               accept;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_channel_0   <= REF_CH0_RESET;
      ref_channel_1   <= REF_CH1_RESET;
      ref_channel_2   <= REF_CH2_RESET;
      match_threshold <= THRESHOLD_RESET;
      distance_mode   <= MODE_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_REF_CH0:   ref_channel_0   <= cfg_wdata[CH_W-1:0];
        CFG_REF_CH1:   ref_channel_1   <= cfg_wdata[CH_W-1:0];
        CFG_REF_CH2:   ref_channel_2   <= cfg_wdata[CH_W-1:0];
        CFG_THRESHOLD: match_threshold <= cfg_wdata[THR_W-1:0];
        CFG_MODE:      distance_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Per-channel differences, hue fold and the saturation third.
  always_comb begin
    diff_0      = absdiff(pix.channel_0, ref_channel_0);
    diff_1      = absdiff(pix.channel_1, ref_channel_1);
    diff_2      = absdiff(pix.channel_2, ref_channel_2);
    hue_term    = (diff_0 > HUE_HALF) ? absdiff(HUE_FULL, diff_0) : diff_0;
    sat_product = (2*CH_W)'(diff_1) * (2*CH_W)'(THIRD_RECIP);
    sat_third   = CH_W'(sat_product >> THIRD_SHIFT);
  end

  // Distance for the selected mode and the match decision.
  always_comb begin
    case (distance_mode)
      MODE_SAD: distance = DIST_W'(diff_0) + DIST_W'(diff_1) + DIST_W'(diff_2);
      MODE_HUE: distance = DIST_W'(hue_term) + DIST_W'(sat_third);
      default:  distance = '0;
    endcase
    match     = distance < match_threshold;
    add_pixel = match && (pixel_count < COUNT_W'(CountCap));
  end

  // Running sums including the current pixel.
  always_comb begin
    column_sum_next  = column_sum + (add_pixel ? SUM_W'(pix.pixel_x) : '0);
    row_sum_next     = row_sum + (add_pixel ? SUM_W'(pix.pixel_y) : '0);
    pixel_count_next = pixel_count + (add_pixel ? COUNT_W'(1) : '0);
  end

  // Every accepted pixel goes straight into the queue.
  assign accept     = pix.valid && push_ready;
  assign pix.ready  = push_ready;
  assign push_valid = pix.valid;

  always_comb begin
    push_data.mask_bit     = match;
    push_data.end_of_frame = pix.end_of_frame;
    push_data.column_sum   = column_sum_next;
    push_data.row_sum      = row_sum_next;
    push_data.pixel_count  = pixel_count_next;
  end

  // Frame accumulators, cleared after the last pixel of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_sum  <= '0;
      row_sum     <= '0;
      pixel_count <= '0;
    end else if (accept) begin
      if (pix.end_of_frame) begin
        column_sum  <= '0;
        row_sum     <= '0;
        pixel_count <= '0;
      end else begin
        column_sum  <= column_sum_next;
        row_sum     <= row_sum_next;
        pixel_count <= pixel_count_next;
      end
    end
  end

  `CMC_ASSERT_SAME(a_empty_sums, pixel_count == '0, column_sum == '0 && row_sum == '0, "sums nonzero with zero count")
  `CMC_ASSERT_NEXT(a_frame_clear, accept && pix.end_of_frame, pixel_count == '0, "count not cleared after frame end")

endmodule

FILE: src/cmc_queue.sv
// ----------------------------------------------------------------------------
// Color mask centroid queue
// Short first-in first-out buffer of classified pixels between the front end
// and the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`include "color_mask_centroid_defines.svh"

module cmc_queue #(
  parameter int unsigned DEPTH = cmc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  cmc_pkg::q_entry_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output cmc_pkg::q_entry_t pop_data,
  input  logic              pop_ready
);
  import cmc_pkg::*;

  localparam int unsigned PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);

  q_entry_t          slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [FillW-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != FillW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth; the fill level tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + FillW'(1);
        2'b01:   fill <= fill - FillW'(1);
        default: ;
      endcase
    end
  end

  `CMC_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FillW'(DEPTH), "queue fill beyond depth")

endmodule

FILE: src/cmc_back.sv
// ----------------------------------------------------------------------------
// Color mask centroid back end
// Drains the queue into the result register. Ordinary pixels pass straight
// through; a frame-end pixel runs a bit-serial division of both sums by the
// match count before its result is shown.
// ----------------------------------------------------------------------------
`include "color_mask_centroid_defines.svh"

module cmc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  cmc_pkg::q_entry_t pop_data,
  output logic              pop_ready,
  cmc_result_if.source      res
);
  import cmc_pkg::*;

  localparam int unsigned StepW = $clog2(CENT_W);

  typedef enum logic [1:0] {
    S_PASS,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t             state;
  logic [StepW-1:0]   step;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W-1:0] rem_x;
  logic [COUNT_W-1:0] rem_y;
  logic [CENT_W-1:0]  quo_x;
  logic [CENT_W-1:0]  quo_y;
  logic               frame_mask;

  logic [COUNT_W:0]   shift_x;
  logic [COUNT_W:0]   shift_y;
  logic               ge_x;
  logic               ge_y;
  logic               out_free;
  logic               show_pixel;
  logic               show_frame;

  // One restoring division step for each coordinate.
  always_comb begin
    shift_x = {rem_x, quo_x[CENT_W-1]};
    shift_y = {rem_y, quo_y[CENT_W-1]};
    ge_x    = shift_x >= {1'b0, divisor};
    ge_y    = shift_y >= {1'b0, divisor};
  end

  assign out_free  = !res.valid || res.ready;
  assign pop_ready = (state == S_PASS) && (pop_data.end_of_frame || out_free);

  // A result is loaded for a passed-through pixel or for a finished division.
  assign show_pixel = (state == S_PASS) && pop_valid && pop_ready && !pop_data.end_of_frame;
  assign show_frame = (state == S_DONE) && out_free;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PASS;
      res.valid <= 1'b0;
    end else begin
      res.valid <= show_pixel || show_frame || (res.valid && !res.ready);
      case (state)
        S_PASS: begin
          if (pop_valid && pop_ready) begin
            if (pop_data.end_of_frame) begin
              // The mean fits in the centroid width, so the upper part of each
              // sum starts below the count and only the low bits are divided.
              rem_x      <= COUNT_W'(pop_data.column_sum[SUM_W-1:CENT_W]);
              rem_y      <= COUNT_W'(pop_data.row_sum[SUM_W-1:CENT_W]);
              quo_x      <= pop_data.column_sum[CENT_W-1:0];
              quo_y      <= pop_data.row_sum[CENT_W-1:0];
              divisor    <= pop_data.pixel_count;
              frame_mask <= pop_data.mask_bit;
              step       <= '0;
              state      <= S_DIVIDE;
            end else begin
              res.mask_bit    <= pop_data.mask_bit;
              res.frame_done  <= 1'b0;
              res.centroid_x  <= '0;
              res.centroid_y  <= '0;
              res.match_count <= '0;
            end
          end
        end
        S_DIVIDE: begin
          rem_x <= COUNT_W'(ge_x ? shift_x - {1'b0, divisor} : shift_x);
          rem_y <= COUNT_W'(ge_y ? shift_y - {1'b0, divisor} : shift_y);
          quo_x <= {quo_x[CENT_W-2:0], ge_x};
          quo_y <= {quo_y[CENT_W-2:0], ge_y};
          step  <= step + StepW'(1);
          if (step == StepW'(CENT_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            // An empty frame reports a centroid of zero.
            res.mask_bit    <= frame_mask;
            res.frame_done  <= 1'b1;
            res.centroid_x  <= (divisor == '0) ? '0 : quo_x;
            res.centroid_y  <= (divisor == '0) ? '0 : quo_y;
            res.match_count <= divisor;
            state           <= S_PASS;
          end
        end
        default: state <= S_PASS;
      endcase
    end
  end

  `CMC_ASSERT_SAME(a_no_pop_busy, state != S_PASS, !pop_ready, "queue popped during division")
  `CMC_ASSERT_SAME(a_plain_zero, res.valid && !res.frame_done, res.centroid_x == '0 && res.centroid_y == '0 && res.match_count == '0, "centroid fields set on ordinary pixel")

endmodule

FILE: src/color_mask_centroid.sv
// ----------------------------------------------------------------------------
// Color mask centroid
// Per-pixel color threshold mask with a per-frame centroid of the matches.
// ----------------------------------------------------------------------------
// Each pixel request yields one result request with its mask bit. A pixel
// that does not end a frame is classified and accumulated in the cycle it is
// accepted and then passes through the queue into the result register, so
// such pixels stream at one per clock while results are taken and no
// division runs. A frame-end pixel is held in the back end to be loaded, run
// through ten bit-serial division steps that produce the column and row means
// together, and presented; the queue (four entries by default) keeps taking
// pixels meanwhile, so the pixel input stalls once it is full. The centroid
// is the floored mean of matching columns and rows, zero for a frame with no
// matches. Configuration must be written only while no pixel is in flight.
module color_mask_centroid #(
  parameter int unsigned MAX_WIDTH   = cmc_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned MAX_HEIGHT  = cmc_pkg::MAX_HEIGHT_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = cmc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  cmc_pixel_if.sink                      pix,
  cmc_result_if.source                   res,
  input  logic                           cfg_wen,
  input  logic [cmc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cmc_pkg::*;

  logic     push_valid;
  logic     push_ready;
  q_entry_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  q_entry_t pop_data;

  // Classification, configuration and frame sums.
  cmc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // Decoupling queue.
  cmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // Centroid division and result register.
  cmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .res       (res)
  );

endmodule
